### sv/vau_pkg.sv
// Shared types, constants and helper functions of the 3D vector unit.
`default_nettype none

package vau_pkg;

    // component format
    localparam int COMP_W = 32;
    localparam int FRAC_W = 16;

    // derived datapath widths
    localparam int PROD_W = 2 * COMP_W;
    localparam int RP_W   = PROD_W - FRAC_W + 1;
    localparam int SAT_W  = RP_W + 3;
    localparam int ROOT_W = COMP_W;
    localparam int RAD_W  = PROD_W;
    localparam int REM_W  = ROOT_W + 2;
    localparam int N_W    = ROOT_W + 1;
    localparam int QUO_W  = FRAC_W + 1;
    localparam int QR_W   = QUO_W + 1;
    localparam int NLANE  = 3;
    localparam int NMUL   = 6;

    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_W - 1);

    typedef enum logic [2:0] {
        OP_ADD   = 3'd0,
        OP_SUB   = 3'd1,
        OP_NEG   = 3'd2,
        OP_SCALE = 3'd3,
        OP_DOT   = 3'd4,
        OP_CROSS = 3'd5,
        OP_NORM  = 3'd6,
        OP_UNIT  = 3'd7
    } t_op;

    // saturated component plus its overflow flag
    typedef struct packed {
        logic              ovf;
        logic [COMP_W-1:0] val;
    } t_sat;

    // per-item results and operand data carried down the whole chain
    typedef struct packed {
        t_op                          op;
        logic [COMP_W-1:0]            res_x;
        logic [COMP_W-1:0]            res_y;
        logic [COMP_W-1:0]            res_z;
        logic [COMP_W-1:0]            res_s;
        logic                         ovf;
        logic                         zero;
        logic [NLANE-1:0][COMP_W-1:0] mag;
        logic [NLANE-1:0]             sgn;
    } t_pay;

    // square root recurrence state
    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [ROOT_W-1:0] root;
        logic [REM_W-1:0]  rem;
    } t_sq;

    // one division lane
    typedef struct packed {
        logic [N_W-1:0]   rem;
        logic             nb;
        logic [QUO_W-1:0] quo;
    } t_dl;

    // division state for all three lanes, common divisor
    typedef struct packed {
        logic [N_W-1:0]        n;
        t_dl [NLANE-1:0]       lane;
    } t_dv;

    // magnitude of a two's complement component
    function automatic logic [COMP_W-1:0] mag_of(input logic [COMP_W-1:0] v);
        return v[COMP_W-1] ? (~v + 1'b1) : v;
    endfunction

    // clamp a wide signed value to the component range
    function automatic t_sat sat_w(input logic [SAT_W-1:0] v);
        logic [SAT_W-1:0] hi;
        logic [SAT_W-1:0] lo;
        t_sat             r;
        hi = {{(SAT_W-COMP_W+1){1'b0}}, {(COMP_W-1){1'b1}}};
        lo = {{(SAT_W-COMP_W+1){1'b1}}, {(COMP_W-1){1'b0}}};
        if ($signed(v) > $signed(hi)) begin
            r.ovf = 1'b1;
            r.val = hi[COMP_W-1:0];
        end else if ($signed(v) < $signed(lo)) begin
            r.ovf = 1'b1;
            r.val = lo[COMP_W-1:0];
        end else begin
            r.ovf = 1'b0;
            r.val = v[COMP_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### sv/vau_if.sv
// Valid/ready channel interfaces for operand items and result items.
`default_nettype none

interface vau_in_if;
    logic                       valid;
    logic                       ready;
    logic [2:0]                 operation;
    logic [vau_pkg::COMP_W-1:0] a_x;
    logic [vau_pkg::COMP_W-1:0] a_y;
    logic [vau_pkg::COMP_W-1:0] a_z;
    logic [vau_pkg::COMP_W-1:0] b_x;
    logic [vau_pkg::COMP_W-1:0] b_y;
    logic [vau_pkg::COMP_W-1:0] b_z;
    logic [vau_pkg::COMP_W-1:0] scale_factor;

    modport source (output valid, operation, a_x, a_y, a_z, b_x, b_y, b_z, scale_factor,
                    input ready);
    modport sink (input valid, operation, a_x, a_y, a_z, b_x, b_y, b_z, scale_factor,
                  output ready);
endinterface

interface vau_out_if;
    logic                       valid;
    logic                       ready;
    logic [vau_pkg::COMP_W-1:0] res_x;
    logic [vau_pkg::COMP_W-1:0] res_y;
    logic [vau_pkg::COMP_W-1:0] res_z;
    logic [vau_pkg::COMP_W-1:0] res_scalar;
    logic                       overflow;
    logic                       zero_length;

    modport source (output valid, res_x, res_y, res_z, res_scalar, overflow, zero_length,
                    input ready);
    modport sink (input valid, res_x, res_y, res_z, res_scalar, overflow, zero_length,
                  output ready);
endinterface

`default_nettype wire

### sv/vau_front.sv
// Front end: products, rounding and all non-root operations, three stages.
`default_nettype none

module vau_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_vld,
    output logic                               o_rdy,
    input  wire logic [2:0]                    i_op,
    input  wire logic [vau_pkg::COMP_W-1:0]    i_ax,
    input  wire logic [vau_pkg::COMP_W-1:0]    i_ay,
    input  wire logic [vau_pkg::COMP_W-1:0]    i_az,
    input  wire logic [vau_pkg::COMP_W-1:0]    i_bx,
    input  wire logic [vau_pkg::COMP_W-1:0]    i_by,
    input  wire logic [vau_pkg::COMP_W-1:0]    i_bz,
    input  wire logic [vau_pkg::COMP_W-1:0]    i_sf,
    input  wire logic                          i_go,
    output logic                               o_vld,
    output vau_pkg::t_pay                      o_pay,
    output vau_pkg::t_sq                       o_sq
);

    localparam int CW = vau_pkg::COMP_W;
    localparam int PW = vau_pkg::PROD_W;
    localparam int RW = vau_pkg::RP_W;
    localparam int SW = vau_pkg::SAT_W;
    localparam int NM = vau_pkg::NMUL;

    // stage valids and advance enables
    logic r_v1, r_v2, r_v3;
    logic go1, go2, go3;

    assign go3   = !r_v3 || i_go;
    assign go2   = !r_v2 || go3;
    assign go1   = !r_v1 || go2;
    assign o_rdy = go1;
    assign o_vld = r_v3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (go1) r_v1 <= i_vld;
            if (go2) r_v2 <= r_v1;
            if (go3) r_v3 <= r_v2;
        end
    end

    // stage 1: operand routing and magnitude products
    vau_pkg::t_op              op_in;
    logic [NM-1:0][CW-1:0]     mx, my;
    logic [NM-1:0][PW-1:0]     n_prod;
    logic [NM-1:0]             n_psg;

    assign op_in = vau_pkg::t_op'(i_op);

    always_comb begin
        mx = '0;
        my = '0;
        unique case (op_in)
            vau_pkg::OP_SCALE: begin
                mx[0] = i_sf; my[0] = i_ax;
                mx[1] = i_sf; my[1] = i_ay;
                mx[2] = i_sf; my[2] = i_az;
            end
            vau_pkg::OP_DOT: begin
                mx[0] = i_ax; my[0] = i_bx;
                mx[1] = i_ay; my[1] = i_by;
                mx[2] = i_az; my[2] = i_bz;
            end
            vau_pkg::OP_CROSS: begin
                mx[0] = i_ay; my[0] = i_bz;
                mx[1] = i_az; my[1] = i_bx;
                mx[2] = i_ax; my[2] = i_by;
                mx[3] = i_az; my[3] = i_by;
                mx[4] = i_ax; my[4] = i_bz;
                mx[5] = i_ay; my[5] = i_bx;
            end
            vau_pkg::OP_NORM, vau_pkg::OP_UNIT: begin
                mx[0] = i_ax; my[0] = i_ax;
                mx[1] = i_ay; my[1] = i_ay;
                mx[2] = i_az; my[2] = i_az;
            end
            default: begin
                mx = '0;
                my = '0;
            end
        endcase
        for (int k = 0; k < NM; k++) begin
            n_prod[k] = PW'(vau_pkg::mag_of(mx[k])) * PW'(vau_pkg::mag_of(my[k]));
            n_psg[k]  = mx[k][CW-1] ^ my[k][CW-1];
        end
    end

    logic [NM-1:0][PW-1:0] r_prod;
    logic [NM-1:0]         r_psg;
    vau_pkg::t_op          r_op1, r_op2;
    logic [2:0][CW-1:0]    r_a1, r_b1, r_a2, r_b2;

    always_ff @(posedge i_clk) begin
        if (go1) begin
            r_prod <= n_prod;
            r_psg  <= n_psg;
            r_op1  <= op_in;
            r_a1   <= {i_az, i_ay, i_ax};
            r_b1   <= {i_bz, i_by, i_bx};
        end
    end

    // stage 2: round products, sum of squares
    logic [NM-1:0][RW-1:0] n_rp, r_rp;
    logic [PW-1:0]         n_ssq, r_ssq;

    always_comb begin
        logic [PW-1:0] t;
        for (int k = 0; k < NM; k++) begin
            t       = r_prod[k] + vau_pkg::ROUND_HALF;
            n_rp[k] = r_psg[k] ? -{1'b0, t[PW-1:vau_pkg::FRAC_W]}
                               :  {1'b0, t[PW-1:vau_pkg::FRAC_W]};
        end
        n_ssq = r_prod[0] + r_prod[1] + r_prod[2];
    end

    always_ff @(posedge i_clk) begin
        if (go2) begin
            r_rp  <= n_rp;
            r_ssq <= n_ssq;
            r_op2 <= r_op1;
            r_a2  <= r_a1;
            r_b2  <= r_b1;
        end
    end

    // stage 3: combine and saturate
    vau_pkg::t_pay n_pay;
    vau_pkg::t_sq  n_sq;

    always_comb begin
        logic [2:0][SW-1:0] wa, wb;
        logic [NM-1:0][SW-1:0] wr;
        vau_pkg::t_sat sx, sy, sz, ss;
        for (int i = 0; i < 3; i++) begin
            wa[i] = {{(SW-CW){r_a2[i][CW-1]}}, r_a2[i]};
            wb[i] = {{(SW-CW){r_b2[i][CW-1]}}, r_b2[i]};
        end
        for (int k = 0; k < NM; k++) begin
            wr[k] = {{(SW-RW){r_rp[k][RW-1]}}, r_rp[k]};
        end
        sx = '0; sy = '0; sz = '0; ss = '0;
        unique case (r_op2)
            vau_pkg::OP_ADD: begin
                sx = vau_pkg::sat_w(wa[0] + wb[0]);
                sy = vau_pkg::sat_w(wa[1] + wb[1]);
                sz = vau_pkg::sat_w(wa[2] + wb[2]);
            end
            vau_pkg::OP_SUB: begin
                sx = vau_pkg::sat_w(wa[0] - wb[0]);
                sy = vau_pkg::sat_w(wa[1] - wb[1]);
                sz = vau_pkg::sat_w(wa[2] - wb[2]);
            end
            vau_pkg::OP_NEG: begin
                sx = vau_pkg::sat_w(-wa[0]);
                sy = vau_pkg::sat_w(-wa[1]);
                sz = vau_pkg::sat_w(-wa[2]);
            end
            vau_pkg::OP_SCALE: begin
                sx = vau_pkg::sat_w(wr[0]);
                sy = vau_pkg::sat_w(wr[1]);
                sz = vau_pkg::sat_w(wr[2]);
            end
            vau_pkg::OP_DOT: begin
                ss = vau_pkg::sat_w(wr[0] + wr[1] + wr[2]);
            end
            vau_pkg::OP_CROSS: begin
                sx = vau_pkg::sat_w(wr[0] - wr[3]);
                sy = vau_pkg::sat_w(wr[1] - wr[4]);
                sz = vau_pkg::sat_w(wr[2] - wr[5]);
            end
            default: begin
                sx = '0;
            end
        endcase
        n_pay.op    = r_op2;
        n_pay.res_x = sx.val;
        n_pay.res_y = sy.val;
        n_pay.res_z = sz.val;
        n_pay.res_s = ss.val;
        n_pay.ovf   = sx.ovf | sy.ovf | sz.ovf | ss.ovf;
        n_pay.zero  = 1'b0;
        for (int i = 0; i < 3; i++) begin
            n_pay.mag[i] = vau_pkg::mag_of(r_a2[i]);
            n_pay.sgn[i] = r_a2[i][CW-1];
        end
        n_sq.rad  = r_ssq;
        n_sq.root = '0;
        n_sq.rem  = '0;
    end

    always_ff @(posedge i_clk) begin
        if (go3) begin
            o_pay <= n_pay;
            o_sq  <= n_sq;
        end
    end

endmodule

`default_nettype wire

### sv/vau_sqrt_cell.sv
// One square root cell: settles one root bit per item.
`default_nettype none

module vau_sqrt_cell (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_vld,
    output logic               o_rdy,
    input  wire vau_pkg::t_pay i_pay,
    input  wire vau_pkg::t_sq  i_sq,
    input  wire logic          i_go,
    output logic               o_vld,
    output vau_pkg::t_pay      o_pay,
    output vau_pkg::t_sq       o_sq
);

    localparam int TW = vau_pkg::REM_W + 2;

    logic r_vld;
    logic go;

    assign go    = !r_vld || i_go;
    assign o_rdy = go;
    assign o_vld = r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (go) begin
            r_vld <= i_vld;
        end
    end

    // trial subtract of (root*4+1) from the remainder with two new bits
    vau_pkg::t_sq n_sq;

    always_comb begin
        logic [TW-1:0] part;
        logic [TW-1:0] trial;
        logic [TW-1:0] diff;
        logic          ge;
        part  = {i_sq.rem, i_sq.rad[vau_pkg::RAD_W-1 -: 2]};
        trial = {{(TW-vau_pkg::ROOT_W-2){1'b0}}, i_sq.root, 2'b01};
        ge    = part >= trial;
        diff  = part - trial;
        n_sq.rem  = ge ? diff[vau_pkg::REM_W-1:0] : part[vau_pkg::REM_W-1:0];
        n_sq.root = {i_sq.root[vau_pkg::ROOT_W-2:0], ge};
        n_sq.rad  = {i_sq.rad[vau_pkg::RAD_W-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            o_pay <= i_pay;
            o_sq  <= n_sq;
        end
    end

endmodule

`default_nettype wire

### sv/vau_div_cell.sv
// One division cell: settles one quotient bit in each of the three lanes.
`default_nettype none

module vau_div_cell (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_vld,
    output logic               o_rdy,
    input  wire vau_pkg::t_pay i_pay,
    input  wire vau_pkg::t_dv  i_dv,
    input  wire logic          i_go,
    output logic               o_vld,
    output vau_pkg::t_pay      o_pay,
    output vau_pkg::t_dv       o_dv
);

    localparam int NW = vau_pkg::N_W;
    localparam int QW = vau_pkg::QUO_W;

    logic r_vld;
    logic go;

    assign go    = !r_vld || i_go;
    assign o_rdy = go;
    assign o_vld = r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (go) begin
            r_vld <= i_vld;
        end
    end

    // restoring step per lane
    vau_pkg::t_dv n_dv;

    always_comb begin
        logic [NW:0] part;
        logic [NW:0] dvs;
        logic [NW:0] diff;
        logic        ge;
        n_dv.n = i_dv.n;
        dvs    = {1'b0, i_dv.n};
        for (int l = 0; l < vau_pkg::NLANE; l++) begin
            part = {i_dv.lane[l].rem, i_dv.lane[l].nb};
            ge   = part >= dvs;
            diff = part - dvs;
            n_dv.lane[l].rem = ge ? diff[NW-1:0] : part[NW-1:0];
            n_dv.lane[l].nb  = 1'b0;
            n_dv.lane[l].quo = {i_dv.lane[l].quo[QW-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            o_pay <= i_pay;
            o_dv  <= n_dv;
        end
    end

endmodule

`default_nettype wire

### sv/vector3_arithmetic_unit.sv
// Top level: front end, square root chain, divide chain and result register.
// Stages in order: 3 front stages, 32 root cells, 1 root rounding stage,
// 17 divide cells and 1 output register.
// Throughput: one item per cycle unless the output stalls; each stage advances
// whenever the stage after it is empty or moving, so bubbles close up under output stall.
// Reset: synchronous active-low reset clears all stage valids; no state else.
`default_nettype none

module vector3_arithmetic_unit (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    vau_in_if.sink    i_in,
    vau_out_if.source o_out
);

    localparam int CW = vau_pkg::COMP_W;
    localparam int RT = vau_pkg::ROOT_W;
    localparam int QW = vau_pkg::QUO_W;
    localparam int NW = vau_pkg::N_W;
    localparam int QR = vau_pkg::QR_W;

    // square root chain links
    logic          sq_vld [RT+1];
    logic          sq_rdy [RT+1];
    vau_pkg::t_pay sq_pay [RT+1];
    vau_pkg::t_sq  sq_st  [RT+1];

    // divide chain links
    logic          dv_vld [QW+1];
    logic          dv_rdy [QW+1];
    vau_pkg::t_pay dv_pay [QW+1];
    vau_pkg::t_dv  dv_st  [QW+1];

    vau_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (i_in.valid),
        .o_rdy   (i_in.ready),
        .i_op    (i_in.operation),
        .i_ax    (i_in.a_x),
        .i_ay    (i_in.a_y),
        .i_az    (i_in.a_z),
        .i_bx    (i_in.b_x),
        .i_by    (i_in.b_y),
        .i_bz    (i_in.b_z),
        .i_sf    (i_in.scale_factor),
        .i_go    (sq_rdy[0]),
        .o_vld   (sq_vld[0]),
        .o_pay   (sq_pay[0]),
        .o_sq    (sq_st[0])
    );

    for (genvar k = 0; k < RT; k++) begin : g_sqrt
        vau_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (sq_vld[k]),
            .o_rdy   (sq_rdy[k]),
            .i_pay   (sq_pay[k]),
            .i_sq    (sq_st[k]),
            .i_go    (sq_rdy[k+1]),
            .o_vld   (sq_vld[k+1]),
            .o_pay   (sq_pay[k+1]),
            .o_sq    (sq_st[k+1])
        );
    end

    // root rounding, norm result and divider setup
    logic r_rn_vld;
    logic rn_go;

    assign rn_go      = !r_rn_vld || dv_rdy[0];
    assign sq_rdy[RT] = rn_go;
    assign dv_vld[0]  = r_rn_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rn_vld <= 1'b0;
        end else if (rn_go) begin
            r_rn_vld <= sq_vld[RT];
        end
    end

    vau_pkg::t_pay n_rn_pay;
    vau_pkg::t_dv  n_rn_dv;

    always_comb begin
        vau_pkg::t_sq  s;
        logic [NW-1:0] n;
        s = sq_st[RT];
        n = {1'b0, s.root} + NW'(s.rem > {2'b00, s.root});
        n_rn_pay = sq_pay[RT];
        if (sq_pay[RT].op == vau_pkg::OP_NORM) begin
            if (n[NW-1:CW-1] != '0) begin
                n_rn_pay.res_s = {1'b0, {(CW-1){1'b1}}};
                n_rn_pay.ovf   = 1'b1;
            end else begin
                n_rn_pay.res_s = n[CW-1:0];
            end
        end
        if (sq_pay[RT].op == vau_pkg::OP_UNIT && n == '0) begin
            n_rn_pay.zero = 1'b1;
        end
        n_rn_dv.n = n;
        for (int l = 0; l < vau_pkg::NLANE; l++) begin
            n_rn_dv.lane[l].rem = NW'(sq_pay[RT].mag[l][CW-1:1]);
            n_rn_dv.lane[l].nb  = sq_pay[RT].mag[l][0];
            n_rn_dv.lane[l].quo = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rn_go) begin
            dv_pay[0] <= n_rn_pay;
            dv_st[0]  <= n_rn_dv;
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_div
        vau_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (dv_vld[k]),
            .o_rdy   (dv_rdy[k]),
            .i_pay   (dv_pay[k]),
            .i_dv    (dv_st[k]),
            .i_go    (dv_rdy[k+1]),
            .o_vld   (dv_vld[k+1]),
            .o_pay   (dv_pay[k+1]),
            .o_dv    (dv_st[k+1])
        );
    end

    // quotient rounding and result register
    logic r_out_vld;
    logic out_go;

    assign out_go     = !r_out_vld || o_out.ready;
    assign dv_rdy[QW] = out_go;
    assign o_out.valid = r_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_go) begin
            r_out_vld <= dv_vld[QW];
        end
    end

    logic [2:0][CW-1:0] n_res;
    logic [CW-1:0]      n_scl;
    logic               n_ovf;
    logic               n_zero;

    always_comb begin
        vau_pkg::t_pay p;
        vau_pkg::t_dv  d;
        logic [QR-1:0] qr;
        logic [CW-1:0] qe;
        p = dv_pay[QW];
        d = dv_st[QW];
        n_res  = {p.res_z, p.res_y, p.res_x};
        n_scl  = p.res_s;
        n_ovf  = p.ovf;
        n_zero = p.zero;
        for (int l = 0; l < vau_pkg::NLANE; l++) begin
            qr = {1'b0, d.lane[l].quo}
               + QR'({d.lane[l].rem, 1'b0} >= {1'b0, d.n});
            qe = {{(CW-QR){1'b0}}, qr};
            if (p.op == vau_pkg::OP_UNIT) begin
                n_res[l] = p.zero ? '0 : (p.sgn[l] ? -qe : qe);
            end
        end
    end

    logic [2:0][CW-1:0] r_res;
    logic [CW-1:0]      r_scl;
    logic               r_ovf;
    logic               r_zero;

    always_ff @(posedge i_clk) begin
        if (out_go) begin
            r_res  <= n_res;
            r_scl  <= n_scl;
            r_ovf  <= n_ovf;
            r_zero <= n_zero;
        end
    end

    assign o_out.res_x       = r_res[0];
    assign o_out.res_y       = r_res[1];
    assign o_out.res_z       = r_res[2];
    assign o_out.res_scalar  = r_scl;
    assign o_out.overflow    = r_ovf;
    assign o_out.zero_length = r_zero;

    // checks
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out.valid)
        else $error("result valid after reset");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_vld |-> i_in.ready)
        else $error("input stalled with empty output register");

    a_zero_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.zero_length) |-> (!o_out.overflow && o_out.res_x == '0
        && o_out.res_y == '0 && o_out.res_z == '0 && o_out.res_scalar == '0))
        else $error("zero-length result not cleared");

    a_scalar_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.res_scalar != '0) |-> (o_out.res_x == '0
        && o_out.res_y == '0 && o_out.res_z == '0))
        else $error("scalar and vector result both set");

endmodule

`default_nettype wire

### bench/vau_scoreboard.sv
// Result predictor and checker for the 3D vector unit bench.
`default_nettype none

module vau_scoreboard (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    vau_in_if         i_in,
    vau_out_if        i_out,
    output int        o_fail_cnt,
    output int        o_pending
);
    import vau_pkg::*;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] s;
        logic        ovf;
        logic        zero;
    } t_vec_result;

    t_vec_result pending_results[$];

    // magnitude of a signed component, as a wide unsigned value
    function automatic logic [127:0] abs_wide(input logic [31:0] v);
        logic [31:0] m;
        m = v[31] ? (~v + 1'b1) : v;
        return {96'b0, m};
    endfunction

    function automatic logic signed [127:0] sext_wide(input logic [31:0] v);
        logic signed [127:0] r;
        r = $signed(v);
        return r;
    endfunction

    // product rounded to the fraction width, halves away from zero
    function automatic logic signed [127:0] round_mul(input logic [31:0] x,
                                                      input logic [31:0] y);
        logic [127:0] p;
        p = abs_wide(x) * abs_wide(y);
        p = (p + (128'd1 << (FRAC_W - 1))) >> FRAC_W;
        return (x[31] ^ y[31]) ? -$signed(p) : $signed(p);
    endfunction

    // clamp to the component range, flag if clipped
    function automatic logic [31:0] clamp32(input logic signed [127:0] v,
                                            inout logic ovf);
        if (v > 128'sh7fffffff) begin
            ovf = 1'b1;
            return 32'h7fffffff;
        end
        if (v < -128'sh80000000) begin
            ovf = 1'b1;
            return 32'h80000000;
        end
        return v[31:0];
    endfunction

    function automatic t_vec_result compute_vector_op(input t_op op,
                                                     input logic [31:0] av[3],
                                                     input logic [31:0] bv[3],
                                                     input logic [31:0] sf);
        t_vec_result  r;
        logic [31:0]  rv[3];
        logic [127:0] sq, root, cand, rem, num, quo, md;
        logic signed [127:0] q;
        int           j, k;
        r.s = '0;
        r.ovf = 1'b0;
        r.zero = 1'b0;
        rv = '{32'd0, 32'd0, 32'd0};
        case (op)
            OP_ADD:
                for (int i = 0; i < 3; i++)
                    rv[i] = clamp32(sext_wide(av[i]) + sext_wide(bv[i]), r.ovf);
            OP_SUB:
                for (int i = 0; i < 3; i++)
                    rv[i] = clamp32(sext_wide(av[i]) - sext_wide(bv[i]), r.ovf);
            OP_NEG:
                for (int i = 0; i < 3; i++)
                    rv[i] = clamp32(-sext_wide(av[i]), r.ovf);
            OP_SCALE:
                for (int i = 0; i < 3; i++)
                    rv[i] = clamp32(round_mul(sf, av[i]), r.ovf);
            OP_DOT:
                r.s = clamp32(round_mul(av[0], bv[0]) + round_mul(av[1], bv[1])
                              + round_mul(av[2], bv[2]), r.ovf);
            OP_CROSS:
                for (int i = 0; i < 3; i++) begin
                    j = (i + 1) % 3;
                    k = (i + 2) % 3;
                    rv[i] = clamp32(round_mul(av[j], bv[k]) - round_mul(av[k], bv[j]),
                                    r.ovf);
                end
            default: begin
                // norm and normalize share the rounded square root
                sq = '0;
                for (int i = 0; i < 3; i++)
                    sq += abs_wide(av[i]) * abs_wide(av[i]);
                root = '0;
                for (int b = 33; b >= 0; b--) begin
                    cand = root | (128'd1 << b);
                    if (cand * cand <= sq)
                        root = cand;
                end
                rem = sq - root * root;
                if (rem > root)
                    root++;
                if (op == OP_NORM) begin
                    r.s = clamp32($signed(root), r.ovf);
                end else if (root == 0) begin
                    r.zero = 1'b1;
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        num = abs_wide(av[i]) << FRAC_W;
                        quo = num / root;
                        md = num % root;
                        if (md >= root - md)
                            quo++;
                        q = av[i][31] ? -$signed(quo) : $signed(quo);
                        rv[i] = clamp32(q, r.ovf);
                    end
                end
            end
        endcase
        r.x = rv[0];
        r.y = rv[1];
        r.z = rv[2];
        return r;
    endfunction

    assign o_pending = pending_results.size();

    // predict on input accept, compare on output accept
    always @(posedge i_clk) begin
        t_vec_result exp_r;
        logic [31:0] av[3], bv[3];
        if (!i_rst_n) begin
            pending_results.delete();
            o_fail_cnt <= 0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                av = '{i_in.a_x, i_in.a_y, i_in.a_z};
                bv = '{i_in.b_x, i_in.b_y, i_in.b_z};
                pending_results.push_back(compute_vector_op(t_op'(i_in.operation), av, bv,
                                                            i_in.scale_factor));
            end
            if (i_out.valid && i_out.ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result x=%h y=%h z=%h s=%h", $time,
                             i_out.res_x, i_out.res_y, i_out.res_z, i_out.res_scalar);
                    o_fail_cnt <= o_fail_cnt + 1;
                end else begin
                    exp_r = pending_results.pop_front();
                    if (exp_r.x !== i_out.res_x || exp_r.y !== i_out.res_y ||
                        exp_r.z !== i_out.res_z || exp_r.s !== i_out.res_scalar ||
                        exp_r.ovf !== i_out.overflow || exp_r.zero !== i_out.zero_length) begin
                        $display("%0t: mismatch expected x=%h y=%h z=%h s=%h ovf=%b zero=%b",
                                 $time, exp_r.x, exp_r.y, exp_r.z, exp_r.s, exp_r.ovf,
                                 exp_r.zero);
                        $display("%0t:          actual   x=%h y=%h z=%h s=%h ovf=%b zero=%b",
                                 $time, i_out.res_x, i_out.res_y, i_out.res_z,
                                 i_out.res_scalar, i_out.overflow, i_out.zero_length);
                        o_fail_cnt <= o_fail_cnt + 1;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

### bench/vector3_arithmetic_unit_tb.sv
// Testbench top: clock, reset, operand stimulus, result back-pressure and verdict.
`default_nettype none

module vector3_arithmetic_unit_tb;
    import vau_pkg::*;

    localparam int RANDOM_ITEMS = 1400;
    localparam int QUIET_ITEMS  = 150;
    localparam int CYCLE_LIMIT  = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic quiet = 1'b0;
    int   fail_cnt, pending_cnt, cycle_cnt = 0;
    int   ready_hold = 0;

    vau_in_if  in_ch ();
    vau_out_if out_ch ();

    vector3_arithmetic_unit i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    vau_scoreboard i_scoreboard (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_ch),
        .i_out     (out_ch),
        .o_fail_cnt(fail_cnt),
        .o_pending (pending_cnt)
    );

    always #5 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // result back-pressure in random bursts, none in the quiet tail
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (ready_hold > 0) begin
            out_ch.ready <= 1'b0;
            ready_hold   <= ready_hold - 1;
        end else if (!quiet && $urandom_range(0, 15) == 0) begin
            out_ch.ready <= 1'b0;
            ready_hold   <= $urandom_range(0, 14);
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // drive one item and hold it until accepted
    task automatic send_item(input t_op op, input logic [31:0] ax, input logic [31:0] ay,
                             input logic [31:0] az, input logic [31:0] bx,
                             input logic [31:0] by, input logic [31:0] bz,
                             input logic [31:0] sf);
        logic taken;
        in_ch.valid        <= 1'b1;
        in_ch.operation    <= op;
        in_ch.a_x          <= ax;
        in_ch.a_y          <= ay;
        in_ch.a_z          <= az;
        in_ch.b_x          <= bx;
        in_ch.b_y          <= by;
        in_ch.b_z          <= bz;
        in_ch.scale_factor <= sf;
        do begin
            @(negedge i_clk);
            taken = in_ch.ready;
            @(posedge i_clk);
        end while (!taken);
    endtask

    task automatic idle_gap(input int cycles);
        in_ch.valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        do @(negedge i_clk); while (pending_cnt != 0);
        @(posedge i_clk);
    endtask

    // component mix: corners, small values, full random
    function automatic logic [31:0] pick_component();
        case ($urandom_range(0, 9))
            0: return 32'h80000000;
            1: return 32'h7fffffff;
            2: return 32'h00000000;
            3: return $urandom_range(0, 1) ? 32'h00010000 : 32'hffff0000;
            4, 5: return 32'($signed($urandom_range(0, 32'h0fffff)) - 32'sh80000);
            6, 7: return 32'($signed($urandom_range(0, 32'h0ffffff)) - 32'sh800000);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic [31:0] v[7];
        t_op         op;
        in_ch.valid        <= 1'b0;
        in_ch.operation    <= OP_ADD;
        in_ch.a_x          <= '0;
        in_ch.a_y          <= '0;
        in_ch.a_z          <= '0;
        in_ch.b_x          <= '0;
        in_ch.b_y          <= '0;
        in_ch.b_z          <= '0;
        in_ch.scale_factor <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corners
        send_item(OP_ADD, 32'h7fffffff, 32'h80000000, 32'h1, 32'h1, 32'hffffffff, 32'h2,
                  32'h0);
        send_item(OP_SUB, 32'h80000000, 32'h7fffffff, 32'h0, 32'h1, 32'hffffffff, 32'h0,
                  32'h0);
        send_item(OP_NEG, 32'h80000000, 32'h7fffffff, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        // half-way rounding, both signs
        send_item(OP_SCALE, 32'h1, 32'hffffffff, 32'h3, 32'h0, 32'h0, 32'h0, 32'h8000);
        send_item(OP_SCALE, 32'h7fffffff, 32'h80000000, 32'h10000, 32'h0, 32'h0, 32'h0,
                  32'h80000000);
        send_item(OP_DOT, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                  32'h80000000, 32'h80000000, 32'h0);
        send_item(OP_DOT, 32'h10000, 32'h20000, 32'hffff8000, 32'h30000, 32'h10000,
                  32'h8000, 32'h0);
        send_item(OP_CROSS, 32'h10000, 32'h0, 32'h0, 32'h0, 32'h10000, 32'h0, 32'h0);
        send_item(OP_CROSS, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                  32'h80000000, 32'h7fffffff, 32'h0);
        send_item(OP_NORM, 32'h30000, 32'h40000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        send_item(OP_NORM, 32'h80000000, 32'h80000000, 32'h80000000, 32'h0, 32'h0, 32'h0,
                  32'h0);
        send_item(OP_NORM, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        send_item(OP_UNIT, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        send_item(OP_UNIT, 32'h30000, 32'hfffc0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        send_item(OP_UNIT, 32'h1, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        send_item(OP_UNIT, 32'h80000000, 32'h7fffffff, 32'h1, 32'h0, 32'h0, 32'h0, 32'h0);
        send_item(OP_UNIT, 32'h1, 32'h1, 32'hffffffff, 32'h0, 32'h0, 32'h0, 32'h0);

        // random items
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS - QUIET_ITEMS)
                quiet <= 1'b1;
            if (n == RANDOM_ITEMS / 2) begin
                in_ch.valid <= 1'b0;
                wait_drained();
            end
            op = t_op'($urandom_range(0, 7));
            foreach (v[i])
                v[i] = pick_component();
            // normalize and norm of a zero or near-zero vector now and then
            if ((op == OP_UNIT || op == OP_NORM) && $urandom_range(0, 5) == 0) begin
                v[0] = '0;
                v[1] = '0;
                v[2] = $urandom_range(0, 1) ? 32'h0 : 32'h1;
            end
            send_item(op, v[0], v[1], v[2], v[3], v[4], v[5], v[6]);
            if (!quiet && $urandom_range(0, 9) == 0)
                idle_gap($urandom_range(1, 15));
        end
        in_ch.valid <= 1'b0;

        wait_drained();
        repeat (60) @(posedge i_clk);
        if (fail_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
